// ----- hw/rtl/ppcx_pkg.sv -----
// ----------------------------------------------------------------------------
// ppcx_pkg
// Shared types, operation codes and helper functions of the integer execute unit.
// ----------------------------------------------------------------------------
package ppcx_pkg;

  localparam int unsigned RegW   = 32;
  localparam int unsigned NumReg = 32;
  localparam int unsigned IdxW   = 5;

  typedef enum logic [4:0] {
    OP_ADDI   = 5'd0,  OP_ADDIS  = 5'd1,  OP_ORI    = 5'd2,  OP_ORIS   = 5'd3,
    OP_ANDI   = 5'd4,  OP_ANDIS  = 5'd5,  OP_CMPLI  = 5'd6,  OP_CMPI   = 5'd7,
    OP_CMP    = 5'd8,  OP_CMPL   = 5'd9,  OP_OR     = 5'd10, OP_AND    = 5'd11,
    OP_EXTSB  = 5'd12, OP_EXTSH  = 5'd13, OP_SUBF   = 5'd14, OP_SUBFIC = 5'd15,
    OP_MULLI  = 5'd16, OP_MULLW  = 5'd17, OP_MULHWU = 5'd18, OP_ADD    = 5'd19,
    OP_ADDE   = 5'd20, OP_RLWINM = 5'd21, OP_RLWIMI = 5'd22, OP_RLWNM  = 5'd23,
    OP_SRAWI  = 5'd24, OP_CNTLZW = 5'd25
  } op_e;

  localparam logic [31:0] CrNibbleTop = 32'hF000_0000;
  localparam logic [31:0] CrLt        = 32'h8000_0000;
  localparam logic [31:0] CrGt        = 32'h4000_0000;
  localparam logic [31:0] CrEq        = 32'h2000_0000;
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [4:0]  action;
    logic [4:0]  reg_field_ds;
    logic [4:0]  reg_field_a;
    logic [4:0]  reg_field_b;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [4:0]  mask_begin;
    logic [4:0]  mask_end;
    logic [2:0]  cr_field;
    logic        record;
  } instr_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  dest_index;
    logic        wrote_register;
    logic [31:0] cond_value;
    logic        carry_out;
    logic        unsupported;
  } result_t;

  function automatic logic [31:0] cmp_flag(logic [31:0] x, logic [31:0] y, logic sgn);
    logic [31:0] xs;
    logic [31:0] ys;
    xs = sgn ? (x ^ 32'h8000_0000) : x;
    ys = sgn ? (y ^ 32'h8000_0000) : y;
    if (x == y) return CrEq;
    return (xs < ys) ? CrLt : CrGt;
  endfunction

  function automatic logic [31:0] wrap_mask(logic [4:0] mb, logic [4:0] me);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = AllOnes >> mb;
    lo = (me == 5'd31) ? 32'd0 : (AllOnes >> ({1'b0, me} + 6'd1));
    return (mb > me) ? ~(hi ^ lo) : (hi ^ lo);
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
    logic [63:0] w;
    w = {v, v} << n;
    return w[63:32];
  endfunction

  function automatic logic [5:0] count_lz(logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/ppcx_ram.sv -----
// ----------------------------------------------------------------------------
// ppcx_ram
// Generic single-write synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ppcx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/ppcx_regfile.sv -----
// ----------------------------------------------------------------------------
// ppcx_regfile
// Three-read general register file: one RAM per read port, valid bits for
// reset, bypass of the write in flight.
// ----------------------------------------------------------------------------
module ppcx_regfile (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    re_i,
  input  logic [ppcx_pkg::IdxW-1:0] raddr_ds_i,
  input  logic [ppcx_pkg::IdxW-1:0] raddr_a_i,
  input  logic [ppcx_pkg::IdxW-1:0] raddr_b_i,
  input  logic                    we_i,
  input  logic [ppcx_pkg::IdxW-1:0] waddr_i,
  input  logic [ppcx_pkg::RegW-1:0] wdata_i,
  output logic [ppcx_pkg::RegW-1:0] rdata_ds_o,
  output logic [ppcx_pkg::RegW-1:0] rdata_a_o,
  output logic [ppcx_pkg::RegW-1:0] rdata_b_o
);

  logic [ppcx_pkg::NumReg-1:0] valid_q;
  logic [ppcx_pkg::RegW-1:0]   ram_ds, ram_a, ram_b;
  logic [ppcx_pkg::IdxW-1:0]   addr_ds_q, addr_a_q, addr_b_q;
  logic                        vld_ds_q, vld_a_q, vld_b_q;
  logic                        byp_ds_q, byp_a_q, byp_b_q;
  logic [ppcx_pkg::RegW-1:0]   byp_data_q;

  ppcx_ram #(.Width(ppcx_pkg::RegW), .Depth(ppcx_pkg::NumReg)) u_ram_ds (
    .clk_i, .we_i, .waddr_i, .wdata_i, .re_i, .raddr_i(raddr_ds_i), .rdata_o(ram_ds));
  ppcx_ram #(.Width(ppcx_pkg::RegW), .Depth(ppcx_pkg::NumReg)) u_ram_a (
    .clk_i, .we_i, .waddr_i, .wdata_i, .re_i, .raddr_i(raddr_a_i), .rdata_o(ram_a));
  ppcx_ram #(.Width(ppcx_pkg::RegW), .Depth(ppcx_pkg::NumReg)) u_ram_b (
    .clk_i, .we_i, .waddr_i, .wdata_i, .re_i, .raddr_i(raddr_b_i), .rdata_o(ram_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_ds_q <= 1'b0;
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      byp_ds_q <= 1'b0;
      byp_a_q  <= 1'b0;
      byp_b_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        vld_ds_q <= valid_q[raddr_ds_i];
        vld_a_q  <= valid_q[raddr_a_i];
        vld_b_q  <= valid_q[raddr_b_i];
        byp_ds_q <= we_i && (waddr_i == raddr_ds_i);
        byp_a_q  <= we_i && (waddr_i == raddr_a_i);
        byp_b_q  <= we_i && (waddr_i == raddr_b_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      addr_ds_q  <= raddr_ds_i;
      addr_a_q   <= raddr_a_i;
      addr_b_q   <= raddr_b_i;
      byp_data_q <= wdata_i;
    end
  end

  // write in the read cycle wins; the core also forwards that same write to its operands
  assign rdata_ds_o = byp_ds_q ? byp_data_q : (vld_ds_q ? ram_ds : '0);
  assign rdata_a_o  = byp_a_q  ? byp_data_q : (vld_a_q  ? ram_a  : '0);
  assign rdata_b_o  = byp_b_q  ? byp_data_q : (vld_b_q  ? ram_b  : '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> valid_q[$past(waddr_i)])
    else $error("written register not marked valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re_i && we_i && waddr_i == raddr_a_i) |=> rdata_a_o == $past(wdata_i))
    else $error("same-cycle write not bypassed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_i |=> addr_ds_q == $past(raddr_ds_i) && addr_a_q == $past(raddr_a_i) &&
             addr_b_q == $past(raddr_b_i))
    else $error("read address not held");

endmodule

// ----- hw/rtl/ppcx_alu.sv -----
// ----------------------------------------------------------------------------
// ppcx_alu
// Combinational datapath for one instruction with resolved operands.
// ----------------------------------------------------------------------------
module ppcx_alu (
  input  ppcx_pkg::instr_t  instr_i,
  input  logic [31:0]       vs_i,
  input  logic [31:0]       va_i,
  input  logic [31:0]       vb_i,
  input  logic [31:0]       cr_i,
  input  logic              ca_i,
  output ppcx_pkg::result_t res_o
);

  logic [31:0] uimm, simm, res, m, cr, rot, ahat;
  logic [63:0] prod, mul_b;
  logic [32:0] wide;
  logic [4:0]  dest, sh, rsh;
  logic        wr, rec, unsup, ca;
  logic [4:0]  crsh;

  always_comb begin
    uimm  = {16'd0, instr_i.immediate};
    simm  = {{16{instr_i.immediate[15]}}, instr_i.immediate};
    sh    = instr_i.shift_amount;
    m     = ppcx_pkg::wrap_mask(instr_i.mask_begin, instr_i.mask_end);
    rsh   = (ppcx_pkg::op_e'(instr_i.action) == ppcx_pkg::OP_RLWNM) ? vb_i[4:0] : sh;
    rot   = ppcx_pkg::rotl(vs_i, rsh);
    mul_b = (ppcx_pkg::op_e'(instr_i.action) == ppcx_pkg::OP_MULLI) ?
            {32'd0, simm} : {32'd0, vb_i};
    prod  = {32'd0, va_i} * mul_b;
    ahat  = (instr_i.reg_field_a == '0) ? 32'd0 : va_i;
    res   = '0;
    dest  = instr_i.reg_field_a;
    wr    = 1'b1;
    rec   = instr_i.record;
    unsup = 1'b0;
    ca    = ca_i;
    cr    = cr_i;
    crsh  = {instr_i.cr_field, 2'b00};
    wide  = '0;
    if (instr_i.action > 5'd25) begin
      wr = 1'b0; rec = 1'b0; unsup = 1'b1;
    end else begin
      unique case (ppcx_pkg::op_e'(instr_i.action))
        ppcx_pkg::OP_ADDI:  begin res = ahat + simm; dest = instr_i.reg_field_ds; rec = 1'b0; end
        ppcx_pkg::OP_ADDIS: begin
          res = ahat + {instr_i.immediate, 16'd0}; dest = instr_i.reg_field_ds; rec = 1'b0;
        end
        ppcx_pkg::OP_ORI:   begin res = vs_i | uimm; rec = 1'b0; end
        ppcx_pkg::OP_ORIS:  begin res = vs_i | {instr_i.immediate, 16'd0}; rec = 1'b0; end
        ppcx_pkg::OP_ANDI:  begin res = vs_i & uimm; rec = 1'b1; end
        ppcx_pkg::OP_ANDIS: begin res = vs_i & {instr_i.immediate, 16'd0}; rec = 1'b1; end
        ppcx_pkg::OP_CMPLI, ppcx_pkg::OP_CMPI, ppcx_pkg::OP_CMP, ppcx_pkg::OP_CMPL: begin
          wr = 1'b0; rec = 1'b0;
          cr = (cr_i & ~(ppcx_pkg::CrNibbleTop >> crsh)) |
               (ppcx_pkg::cmp_flag(va_i,
                  (ppcx_pkg::op_e'(instr_i.action) == ppcx_pkg::OP_CMPLI) ? uimm :
                  (ppcx_pkg::op_e'(instr_i.action) == ppcx_pkg::OP_CMPI)  ? simm : vb_i,
                  (ppcx_pkg::op_e'(instr_i.action) == ppcx_pkg::OP_CMPI) ||
                  (ppcx_pkg::op_e'(instr_i.action) == ppcx_pkg::OP_CMP)) >> crsh);
        end
        ppcx_pkg::OP_OR:    res = vs_i | vb_i;
        ppcx_pkg::OP_AND:   res = vs_i & vb_i;
        ppcx_pkg::OP_EXTSB: res = {{24{vs_i[7]}}, vs_i[7:0]};
        ppcx_pkg::OP_EXTSH: res = {{16{vs_i[15]}}, vs_i[15:0]};
        ppcx_pkg::OP_SUBF:  begin res = vb_i - va_i; dest = instr_i.reg_field_ds; end
        ppcx_pkg::OP_SUBFIC: begin
          wide = {1'b0, ~va_i} + {1'b0, simm} + 33'd1;
          res = wide[31:0]; ca = wide[32]; dest = instr_i.reg_field_ds; rec = 1'b0;
        end
        ppcx_pkg::OP_MULLI: begin res = prod[31:0]; dest = instr_i.reg_field_ds; rec = 1'b0; end
        ppcx_pkg::OP_MULLW: begin res = prod[31:0]; dest = instr_i.reg_field_ds; end
        ppcx_pkg::OP_MULHWU: begin res = prod[63:32]; dest = instr_i.reg_field_ds; end
        ppcx_pkg::OP_ADD:   begin res = va_i + vb_i; dest = instr_i.reg_field_ds; end
        ppcx_pkg::OP_ADDE:  begin
          wide = {1'b0, va_i} + {1'b0, vb_i} + {32'd0, ca_i};
          res = wide[31:0]; ca = wide[32]; dest = instr_i.reg_field_ds;
        end
        ppcx_pkg::OP_RLWINM, ppcx_pkg::OP_RLWNM: res = rot & m;
        ppcx_pkg::OP_RLWIMI: res = (rot & m) | (va_i & ~m);
        ppcx_pkg::OP_SRAWI: begin
          res = 32'($signed(vs_i) >>> sh);
          ca  = vs_i[31] && ((vs_i & ~(ppcx_pkg::AllOnes << sh)) != '0);
        end
        ppcx_pkg::OP_CNTLZW: res = {26'd0, ppcx_pkg::count_lz(vs_i)};
        default: begin wr = 1'b0; rec = 1'b0; unsup = 1'b1; end
      endcase
    end
    if (wr && rec) begin
      cr = (cr & ~ppcx_pkg::CrNibbleTop) | ppcx_pkg::cmp_flag(res, 32'd0, 1'b1);
    end
    if (!wr) begin
      res = '0; dest = '0;
    end
    res_o.result_value   = res;
    res_o.dest_index     = dest;
    res_o.wrote_register = wr;
    res_o.cond_value     = cr;
    res_o.carry_out      = ca;
    res_o.unsupported    = unsup;
  end

endmodule

// ----- hw/rtl/ppc_integer_execute_unit_core.sv -----
// ----------------------------------------------------------------------------
// ppc_integer_execute_unit_core
// Path: the instruction and its register reads are registered into the
// execute stage, then the ALU result is registered into the output register.
// Throughput: one instruction per cycle while the output is not stalled; results
// of the previous instruction are forwarded into the next one's operands.
// Reset: asynchronous, clears register file valid bits, CR, carry and pipeline.
// ----------------------------------------------------------------------------
module ppc_integer_execute_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action, reg_field_ds, reg_field_a, reg_field_b, immediate, shift_amount,
  // mask_begin, mask_end, cr_field, record (bits 54:0), zero pad to 56
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value, dest_index, wrote_register, cond_value, carry_out,
  // unsupported (bits 71:0)
  output logic [71:0]  m_axis_tdata
);

  ppcx_pkg::instr_t  in_instr, ex_q;
  ppcx_pkg::result_t alu_res, out_q;
  logic              ex_vld_q, out_vld_q, adv_ex, adv_rd;
  logic [31:0]       rf_ds, rf_a, rf_b, vs, va, vb, cr_q;
  logic              ca_q;
  logic [31:0]       fwd_val_q;
  logic [4:0]        fwd_idx_q;
  logic              fwd_vld_q;

  assign in_instr = ppcx_pkg::instr_t'({s_axis_tdata[0 +: 5], s_axis_tdata[5 +: 5],
    s_axis_tdata[10 +: 5], s_axis_tdata[15 +: 5], s_axis_tdata[20 +: 16],
    s_axis_tdata[36 +: 5], s_axis_tdata[41 +: 5], s_axis_tdata[46 +: 5],
    s_axis_tdata[51 +: 3], s_axis_tdata[54]});

  assign adv_ex        = ex_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !ex_vld_q || adv_ex;
  assign adv_rd        = s_axis_tvalid && s_axis_tready;

  ppcx_regfile u_regfile (
    .clk_i, .rst_ni,
    .re_i(adv_rd),
    .raddr_ds_i(in_instr.reg_field_ds),
    .raddr_a_i(in_instr.reg_field_a),
    .raddr_b_i(in_instr.reg_field_b),
    .we_i(adv_ex && alu_res.wrote_register),
    .waddr_i(alu_res.dest_index),
    .wdata_i(alu_res.result_value),
    .rdata_ds_o(rf_ds), .rdata_a_o(rf_a), .rdata_b_o(rf_b)
  );

  // forward the write made in the cycle of this instruction's read
  assign vs = (fwd_vld_q && fwd_idx_q == ex_q.reg_field_ds) ? fwd_val_q : rf_ds;
  assign va = (fwd_vld_q && fwd_idx_q == ex_q.reg_field_a)  ? fwd_val_q : rf_a;
  assign vb = (fwd_vld_q && fwd_idx_q == ex_q.reg_field_b)  ? fwd_val_q : rf_b;

  ppcx_alu u_alu (
    .instr_i(ex_q), .vs_i(vs), .va_i(va), .vb_i(vb),
    .cr_i(cr_q), .ca_i(ca_q), .res_o(alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cr_q      <= '0;
      ca_q      <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        ex_vld_q <= s_axis_tvalid;
      end
      if (adv_ex) begin
        out_vld_q <= 1'b1;
        cr_q      <= alu_res.cond_value;
        ca_q      <= alu_res.carry_out;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (adv_rd) begin
        fwd_vld_q <= adv_ex && alu_res.wrote_register;
      end else if (adv_ex && alu_res.wrote_register) begin
        fwd_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_rd) begin
      ex_q      <= in_instr;
      fwd_idx_q <= alu_res.dest_index;
      fwd_val_q <= alu_res.result_value;
    end
    if (adv_ex) begin
      out_q <= alu_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.unsupported, out_q.carry_out, out_q.cond_value,
                          out_q.wrote_register, out_q.dest_index, out_q.result_value};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_ex |=> cr_q == $past(alu_res.cond_value) && ca_q == $past(alu_res.carry_out))
    else $error("CR or carry not committed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_rd |-> (!ex_vld_q || adv_ex))
    else $error("instruction overwritten in execute stage");

endmodule
